/* hw/rtl/wtsd_pkg.sv */
// Shared types and constants for the weighted three-frame standard deviation block.
package wtsd_pkg;

  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned STD_DEV_BITS = 8;
  localparam int unsigned RAD_BITS     = 2 * STD_DEV_BITS;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd21845;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WEIGHT_A = 2'd0,
    CFG_WEIGHT_B = 2'd1,
    CFG_WEIGHT_C = 2'd2
  } cfg_reg_e;

  // Load enables for the two root stages.
  typedef struct packed {
    logic en_a;
    logic en_b;
  } sqrt_ctrl_t;

endpackage

/* hw/rtl/wtsd_if.sv */
// Valid/ready channels for pixel requests and standard deviation results.
interface wtsd_pix_if #(
  parameter int unsigned PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_a;
  logic [PIXEL_BITS-1:0] pixel_b;
  logic [PIXEL_BITS-1:0] pixel_c;

  modport source (output valid, output pixel_a, output pixel_b, output pixel_c, input ready);
  modport sink   (input valid, input pixel_a, input pixel_b, input pixel_c, output ready);
endinterface

interface wtsd_res_if
  import wtsd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STD_DEV_BITS-1:0] std_dev;
  logic                    clipped;

  modport source (output valid, output std_dev, output clipped, input ready);
  modport sink   (input valid, input std_dev, input clipped, output ready);
endinterface

/* hw/rtl/wtsd_isqrt.sv */
// Two-stage integer square root of a 16-bit radicand, with saturation on clip.
module wtsd_isqrt
  import wtsd_pkg::*;
(
  input  logic                    clk_i,
  input  sqrt_ctrl_t              ctrl_i,
  input  logic [RAD_BITS-1:0]     rad_i,
  input  logic                    clip_i,
  output logic [STD_DEV_BITS-1:0] std_dev_o,
  output logic                    clipped_o
);

  localparam int unsigned HALF_STEPS = STD_DEV_BITS / 2;
  localparam int unsigned LO_BITS    = RAD_BITS / 2;
  localparam int unsigned REM_W      = RAD_BITS - 4;
  localparam int unsigned REM_A_W    = HALF_STEPS + 1;

  logic [HALF_STEPS-1:0]   root_a_d, root_a_q;
  logic [REM_A_W-1:0]      rem_a_d, rem_a_q;
  logic [LO_BITS-1:0]      lo_a_q;
  logic                    clip_a_q;
  logic [STD_DEV_BITS-1:0] std_dev_d, std_dev_q;
  logic                    clipped_q;

  // Upper four root bits from the upper radicand byte.
  always_comb begin
    logic [REM_W-1:0]        rem;
    logic [REM_W-1:0]        trial;
    logic [STD_DEV_BITS-1:0] root;
    rem  = '0;
    root = '0;
    for (int i = 0; i < HALF_STEPS; i++) begin
      rem   = {rem[REM_W-3:0], rad_i[RAD_BITS-1-2*i -: 2]};
      trial = {2'b00, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[STD_DEV_BITS-2:0], 1'b1};
      end else begin
        root = {root[STD_DEV_BITS-2:0], 1'b0};
      end
    end
    root_a_d = root[HALF_STEPS-1:0];
    rem_a_d  = rem[REM_A_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_a) begin
      root_a_q <= root_a_d;
      rem_a_q  <= rem_a_d;
      lo_a_q   <= rad_i[LO_BITS-1:0];
      clip_a_q <= clip_i;
    end
  end

  // Lower four root bits from the lower radicand byte.
  always_comb begin
    logic [REM_W-1:0]        rem;
    logic [REM_W-1:0]        trial;
    logic [STD_DEV_BITS-1:0] root;
    rem  = REM_W'(rem_a_q);
    root = STD_DEV_BITS'(root_a_q);
    for (int i = 0; i < HALF_STEPS; i++) begin
      rem   = {rem[REM_W-3:0], lo_a_q[LO_BITS-1-2*i -: 2]};
      trial = {2'b00, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[STD_DEV_BITS-2:0], 1'b1};
      end else begin
        root = {root[STD_DEV_BITS-2:0], 1'b0};
      end
    end
    std_dev_d = clip_a_q ? '1 : root;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_b) begin
      std_dev_q <= std_dev_d;
      clipped_q <= clip_a_q;
    end
  end

  assign std_dev_o = std_dev_q;
  assign clipped_o = clipped_q;

endmodule

/* hw/rtl/weighted_three_frame_std_dev.sv */
// Top level: weighted three-frame standard deviation pipeline.
//
// Takes one pixel request per cycle while not stalled (three grey values of
// one position from the oldest, middle and newest frame) and returns
// floor(sqrt(r)) of the weighted variance r, saturated at 255 with a clip
// flag. Throughput is one pixel per cycle without stalls; pipeline depth
// comes from the wide squaring and weighting products being split into
// partial products over separate stages and by the root being resolved four
// bits per stage. Each stage holds its request while the next is full, so
// bubbles close up and requests keep entering while a result waits. Weights
// are unsigned fractions with WEIGHT_FRAC_BITS fractional bits (at most 16
// bits used) and must only be written while no request is in flight.
module weighted_three_frame_std_dev
  import wtsd_pkg::*;
#(
  parameter int unsigned PIXEL_BITS       = 8,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WEIGHT_BITS-1:0]  cfg_wdata_i,
  wtsd_pix_if.sink                pix_i,
  wtsd_res_if.source              res_o
);

  localparam int unsigned P    = PIXEL_BITS;
  localparam int unsigned F    = WEIGHT_FRAC_BITS;
  localparam int unsigned WW   = (F < WEIGHT_BITS) ? F : WEIGHT_BITS;
  localparam int unsigned PW   = P + WW;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned DW   = P + F + 2;
  localparam int unsigned HW   = (DW + 1) / 2;
  localparam int unsigned DH   = DW - HW;
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned CW   = HW;
  localparam int unsigned NCH  = (SQW + CW - 1) / CW;
  localparam int unsigned PADW = NCH * CW;
  localparam int unsigned CPW  = CW + WW;
  localparam int unsigned TW   = SQW + WW;
  localparam int unsigned RW   = TW + 2;
  localparam int unsigned NS   = 9;

  // Configuration
  logic [WEIGHT_BITS-1:0] weight_q [3];
  logic [WW-1:0]          w_eff    [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) weight_q[i] <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WEIGHT_A: weight_q[0] <= cfg_wdata_i;
        CFG_WEIGHT_B: weight_q[1] <= cfg_wdata_i;
        CFG_WEIGHT_C: weight_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) w_eff[i] = weight_q[i][WW-1:0];
  end

  // Stage valids and per-stage load enables
  logic [NS:1] v_q;
  logic [NS:1] v_src;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_q[NS] || res_o.ready;
    for (int k = NS - 1; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign v_src = {v_q[NS-1:1], pix_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_src[k];
      end
    end
  end

  assign pix_i.ready = en[1];

  // Stage 1: weighted pixels
  logic [P-1:0]  pix   [3];
  logic [P-1:0]  p1_q  [3];
  logic [PW-1:0] pw1_d [3];
  logic [PW-1:0] pw1_q [3];

  assign pix[0] = pix_i.pixel_a;
  assign pix[1] = pix_i.pixel_b;
  assign pix[2] = pix_i.pixel_c;

  always_comb begin
    for (int i = 0; i < 3; i++) pw1_d[i] = PW'(pix[i]) * PW'(w_eff[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q  <= pix;
      pw1_q <= pw1_d;
    end
  end

  // Stage 2: scaled mean and absolute deviations
  logic [SW-1:0] mean_sum;
  logic [DW-1:0] dev2_d [3];
  logic [DW-1:0] dev2_q [3];

  always_comb begin
    logic [DW-1:0] ps;
    logic [DW-1:0] ms;
    mean_sum = SW'(pw1_q[0]) + SW'(pw1_q[1]) + SW'(pw1_q[2]);
    ms       = DW'(mean_sum);
    for (int i = 0; i < 3; i++) begin
      ps        = DW'(p1_q[i]) << F;
      dev2_d[i] = (ps >= ms) ? (ps - ms) : (ms - ps);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) dev2_q <= dev2_d;
  end

  // Stage 3: partial squares of the deviation halves
  logic [2*HW-1:0] ll3_d [3], ll3_q [3];
  logic [DW-1:0]   lh3_d [3], lh3_q [3];
  logic [2*DH-1:0] hh3_d [3], hh3_q [3];

  always_comb begin
    logic [HW-1:0] dl;
    logic [DH-1:0] dh;
    for (int i = 0; i < 3; i++) begin
      dl       = dev2_q[i][HW-1:0];
      dh       = dev2_q[i][DW-1:HW];
      ll3_d[i] = (2*HW)'(dl) * (2*HW)'(dl);
      lh3_d[i] = DW'(dl) * DW'(dh);
      hh3_d[i] = (2*DH)'(dh) * (2*DH)'(dh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ll3_q <= ll3_d;
      lh3_q <= lh3_d;
      hh3_q <= hh3_d;
    end
  end

  // Stage 4: full squares
  logic [SQW-1:0] sq4_d [3], sq4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = (SQW'(hh3_q[i]) << (2*HW)) + (SQW'(lh3_q[i]) << (HW+1)) + SQW'(ll3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) sq4_q <= sq4_d;
  end

  // Stage 5: squares times weights, one chunk product per slice
  logic [PADW-1:0] sq_pad [3];
  logic [CPW-1:0]  cp5_d  [3][NCH];
  logic [CPW-1:0]  cp5_q  [3][NCH];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_pad[i] = PADW'(sq4_q[i]);
      for (int j = 0; j < NCH; j++) begin
        cp5_d[i][j] = CPW'(sq_pad[i][j*CW +: CW]) * CPW'(w_eff[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) cp5_q <= cp5_d;
  end

  // Stage 6: weighted squared deviation per frame
  logic [TW-1:0] term6_d [3], term6_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term6_d[i] = '0;
      for (int j = 0; j < NCH; j++) begin
        term6_d[i] = term6_d[i] + (TW'(cp5_q[i][j]) << (j*CW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) term6_q <= term6_d;
  end

  // Stage 7: scaled variance
  logic [RW-1:0] var7_d, var7_q;

  assign var7_d = RW'(term6_q[0]) + RW'(term6_q[1]) + RW'(term6_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[7]) var7_q <= var7_d;
  end

  // Stages 8 and 9: drop the fraction, clip, take the root
  logic [RW-1:0]       var_int;
  logic [RAD_BITS-1:0] rad;
  logic                clip;
  sqrt_ctrl_t          sqrt_ctrl;

  assign var_int = var7_q >> (3*F);
  assign rad     = var_int[RAD_BITS-1:0];
  assign clip    = |var_int[RW-1:RAD_BITS];

  assign sqrt_ctrl.en_a = en[8];
  assign sqrt_ctrl.en_b = en[9];

  wtsd_isqrt u_isqrt (
    .clk_i     (clk_i),
    .ctrl_i    (sqrt_ctrl),
    .rad_i     (rad),
    .clip_i    (clip),
    .std_dev_o (res_o.std_dev),
    .clipped_o (res_o.clipped)
  );

  assign res_o.valid = v_q[NS];

  // Checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v_q[1])
    else $error("accepted request did not enter the first stage");

  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready == (!(&v_q) || res_o.ready))
    else $error("input ready disagrees with pipeline occupancy");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.clipped |-> res_o.std_dev == '1)
    else $error("clipped result not saturated");

  a_stall_keeps_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !en[NS-1] |=> v_q[NS-1] && v_q[NS])
    else $error("stalled stage lost its request");

endmodule

/* tb/tb_weighted_three_frame_std_dev.sv */
// Self-checking testbench for the weighted three-frame standard deviation pipeline.
`timescale 1ns / 1ps

module tb_weighted_three_frame_std_dev;
  import wtsd_pkg::*;

  localparam int unsigned PIXEL_BITS       = 8;
  localparam int unsigned WEIGHT_FRAC_BITS = 16;
  localparam int unsigned LONG_HOLD        = 300;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned SET_ITEMS        = 118;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
  // Index past the three weights; writes to it must not change anything.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] a;
    logic [PIXEL_BITS-1:0] b;
    logic [PIXEL_BITS-1:0] c;
  } pixel_req_t;

  typedef struct packed {
    logic [STD_DEV_BITS-1:0] std_dev;
    logic                    clipped;
  } std_dev_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [WEIGHT_BITS-1:0] cfg_wdata;

  wtsd_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
  wtsd_res_if res_if ();

  weighted_three_frame_std_dev #(
    .PIXEL_BITS      (PIXEL_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  logic [WEIGHT_BITS-1:0] weight_shadow [3];
  pixel_req_t   pixel_pending [$];
  std_dev_res_t std_dev_expected [$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_token;
  int unsigned  hold_seen;
  int unsigned  hold_left;
  int unsigned  mismatches;
  int unsigned  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact weighted variance, then truncated root with saturation.
  function automatic std_dev_res_t weighted_std_dev(pixel_req_t px);
    logic [PIXEL_BITS-1:0] pix [3];
    logic [31:0]  mean_sum;
    logic [31:0]  pix_scaled;
    logic [31:0]  dev;
    logic [127:0] var_acc;
    logic [127:0] radicand;
    logic [STD_DEV_BITS-1:0] root;
    logic [STD_DEV_BITS-1:0] trial;
    std_dev_res_t res;
    pix[0] = px.a;
    pix[1] = px.b;
    pix[2] = px.c;
    mean_sum = '0;
    for (int i = 0; i < 3; i++) begin
      mean_sum += 32'(pix[i]) * 32'(weight_shadow[i]);
    end
    var_acc = '0;
    for (int i = 0; i < 3; i++) begin
      pix_scaled = 32'(pix[i]) << WEIGHT_FRAC_BITS;
      dev = (pix_scaled >= mean_sum) ? pix_scaled - mean_sum : mean_sum - pix_scaled;
      var_acc += 128'(dev) * 128'(dev) * 128'(weight_shadow[i]);
    end
    radicand = var_acc >> (3 * WEIGHT_FRAC_BITS);
    res.clipped = (radicand >= 128'(1 << RAD_BITS));
    root = '0;
    if (!res.clipped) begin
      for (int b = STD_DEV_BITS - 1; b >= 0; b--) begin
        trial = root | (STD_DEV_BITS'(1) << b);
        if (32'(trial) * 32'(trial) <= radicand[31:0]) root = trial;
      end
    end
    res.std_dev = res.clipped ? '1 : root;
    return res;
  endfunction

  // Offer pending requests; predict each one as it is accepted.
  always @(posedge clk) begin : drive_pixels
    pixel_req_t px;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        px.a = pix_if.pixel_a;
        px.b = pix_if.pixel_b;
        px.c = pix_if.pixel_c;
        std_dev_expected.push_back(weighted_std_dev(px));
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixel_pending.pop_front();
          pix_if.valid   <= 1'b1;
          pix_if.pixel_a <= px.a;
          pix_if.pixel_b <= px.b;
          pix_if.pixel_c <= px.c;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure: random stalls plus a single long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= LONG_HOLD;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    std_dev_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (std_dev_expected.size() == 0) begin
        $display("%0t: unexpected result std_dev=%0d clipped=%0d",
                 $time, res_if.std_dev, res_if.clipped);
        mismatches++;
      end else begin
        want = std_dev_expected.pop_front();
        if (res_if.std_dev !== want.std_dev) begin
          $display("%0t: std_dev expected %0d, got %0d", $time, want.std_dev, res_if.std_dev);
          mismatches++;
        end
        if (res_if.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0d, got %0d", $time, want.clipped, res_if.clipped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [WEIGHT_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_WEIGHT_A: weight_shadow[0] = value;
      CFG_WEIGHT_B: weight_shadow[1] = value;
      CFG_WEIGHT_C: weight_shadow[2] = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_weights(logic [WEIGHT_BITS-1:0] wa, logic [WEIGHT_BITS-1:0] wb,
                             logic [WEIGHT_BITS-1:0] wc);
    cfg_write(CFG_WEIGHT_A, wa);
    cfg_write(CFG_WEIGHT_B, wb);
    cfg_write(CFG_WEIGHT_C, wc);
  endtask

  // Hold until every request is accepted and every result is back.
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_pending.size() != 0 || pix_if.valid || std_dev_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_pixel(int unsigned a, int unsigned b, int unsigned c);
    pixel_req_t px;
    px.a = PIXEL_BITS'(a);
    px.b = PIXEL_BITS'(b);
    px.c = PIXEL_BITS'(c);
    pixel_pending.push_back(px);
  endtask

  task automatic queue_random_pixel();
    int base;
    int v [3];
    base = int'($urandom_range(0, 255));
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        1: v[i] = $urandom_range(0, 1) ? 255 : 0;
        2: begin
          v[i] = base + int'($urandom_range(0, 16)) - 8;
          if (v[i] < 0) v[i] = 0;
          if (v[i] > 255) v[i] = 255;
        end
        default: v[i] = int'($urandom_range(0, 255));
      endcase
    end
    queue_pixel(v[0], v[1], v[2]);
  endtask

  initial begin : stimulus
    int unsigned pinned;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_WEIGHT_A;
    cfg_wdata      = '0;
    pix_if.valid   = 1'b0;
    pix_if.pixel_a = '0;
    pix_if.pixel_b = '0;
    pix_if.pixel_c = '0;
    res_if.ready   = 1'b0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token     = 0;
    mismatches     = 0;
    cycle_count    = 0;
    for (int i = 0; i < 3; i++) weight_shadow[i] = WEIGHT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset weights: corners, one-frame changes and alternating bit patterns.
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 128, 255);
    queue_pixel(1, 2, 3);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'h55, 8'hAA, 8'h55);
    wait_idle();

    // Full-scale weights push the root past 255; the spare index is ignored.
    set_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
    cfg_write(CFG_SPARE, 16'h0000);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 0);
    queue_pixel(128, 128, 128);
    queue_pixel(0, 0, 0);
    wait_idle();

    // Weights summing to one, then all zero.
    set_weights(16'd32768, 16'd16384, 16'd16384);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(100, 200, 50);
    wait_idle();
    set_weights('0, '0, '0);
    queue_pixel(255, 0, 128);
    queue_pixel(7, 250, 3);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int set = 0; set < 4; set++) begin
        wait_idle();
        case (set)
          0: begin
            case (ph)
              0: set_weights('0, '0, '0);
              1: set_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
              2: set_weights(WEIGHT_MAX, '0, '0);
              default: set_weights('0, 16'd32768, WEIGHT_MAX);
            endcase
          end
          1: set_weights(WEIGHT_BITS'($urandom_range(0, 65535)),
                         WEIGHT_BITS'($urandom_range(0, 65535)),
                         WEIGHT_BITS'($urandom_range(0, 65535)));
          2: begin
            set_weights(WEIGHT_BITS'($urandom_range(0, 65535)),
                        WEIGHT_BITS'($urandom_range(0, 65535)),
                        WEIGHT_BITS'($urandom_range(0, 65535)));
            pinned = $urandom_range(0, 2);
            cfg_write(CFG_IDX_BITS'(pinned), $urandom_range(0, 1) ? WEIGHT_MAX : '0);
          end
          default: begin
            set_weights(WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
            cfg_write(CFG_SPARE, WEIGHT_BITS'($urandom_range(0, 65535)));
          end
        endcase
        // Stall results long enough for the pipeline to back up into the input.
        if (ph == 0 && set == 1) hold_token++;
        repeat (SET_ITEMS) queue_random_pixel();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && std_dev_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
